>>> rtl/core/lf_pkg.sv
package lf_pkg;

   localparam int LINE_DEPTH = 64;
   localparam int ADDR_W = $clog2(LINE_DEPTH);
   localparam int LEN_W = $clog2(LINE_DEPTH + 1);

   localparam logic [7:0] CHAR_CR = 8'h0D;
   localparam logic [7:0] CHAR_LF = 8'h0A;

endpackage

>>> rtl/core/lf_line_store.sv
module lf_line_store (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [lf_pkg::ADDR_W-1:0]  wr_addr,
   input  logic [7:0]                 wr_data,
   input  logic                       rd_en,
   input  logic [lf_pkg::ADDR_W-1:0]  rd_addr,
   output logic [7:0]                 rd_data
);
   import lf_pkg::*;

   logic [7:0] mem [LINE_DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/line_framer_byte_to_line_core.sv
// Line framer. Each input beat carries one byte, which is written into a 64-byte line
// store; the block takes one byte per cycle while a line is being filled. A carriage
// return, a line feed or a byte that fills the last slot ends the line. The line is
// then read back from the store's single read port, whose read data is registered,
// and sent as one output beat per byte, the last beat marked, with the line length
// and a cut mark for lines ended by a full store on every beat. No input byte is
// taken until the last beat of the line has reached the output register.
module line_framer_byte_to_line_core (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [7:0]                req_data_byte,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [7:0]                rsp_out_byte,
   output logic                      rsp_last_of_line,
   output logic [lf_pkg::LEN_W-1:0]  rsp_line_length,
   output logic                      rsp_cut_by_full
);
   import lf_pkg::*;

   typedef enum logic {ST_FILL, ST_EMIT} state_type;

   state_type          state_ff, state_in;
   logic [ADDR_W-1:0]  fill_pos_ff, fill_pos_in;
   logic [LEN_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic               cut_ff, cut_in;
   logic               pend_ff, pend_in;
   logic               pend_last_ff, pend_last_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [7:0]         rsp_byte_ff, rsp_byte_in;
   logic               rsp_last_ff, rsp_last_in;
   logic [LEN_W-1:0]   rsp_len_ff, rsp_len_in;
   logic               rsp_cut_ff, rsp_cut_in;

   logic               accept;
   logic               is_term;
   logic               is_full;
   logic               load;
   logic               issue;
   logic [7:0]         rd_data;

   lf_line_store u_store (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (fill_pos_ff),
      .wr_data (req_data_byte),
      .rd_en   (issue),
      .rd_addr (rd_ptr_ff[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   always_comb begin
      accept = req_valid && (state_ff == ST_FILL);
      is_term = (req_data_byte == CHAR_CR) || (req_data_byte == CHAR_LF);
      is_full = (fill_pos_ff == ADDR_W'(LINE_DEPTH - 1));
      load = pend_ff && (!rsp_valid_ff || rsp_ready);
      issue = (state_ff == ST_EMIT) && (rd_ptr_ff != len_ff) && (!pend_ff || load);

      state_in = state_ff;
      fill_pos_in = fill_pos_ff;
      rd_ptr_in = rd_ptr_ff;
      len_in = len_ff;
      cut_in = cut_ff;
      pend_in = pend_ff;
      pend_last_in = pend_last_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in = rsp_byte_ff;
      rsp_last_in = rsp_last_ff;
      rsp_len_in = rsp_len_ff;
      rsp_cut_in = rsp_cut_ff;

      if (load) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in = rd_data;
         rsp_last_in = pend_last_ff;
         rsp_len_in = len_ff;
         rsp_cut_in = cut_ff;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (issue) begin
         pend_in = 1'b1;
         pend_last_in = (rd_ptr_ff == len_ff - LEN_W'(1));
         rd_ptr_in = rd_ptr_ff + LEN_W'(1);
      end else if (load) begin
         pend_in = 1'b0;
      end

      case (state_ff)
         ST_FILL: begin
            if (accept) begin
               if (is_term || is_full) begin
                  state_in = ST_EMIT;
                  len_in = LEN_W'(fill_pos_ff) + LEN_W'(1);
                  cut_in = is_full && !is_term;
                  rd_ptr_in = '0;
                  fill_pos_in = '0;
               end else begin
                  fill_pos_in = fill_pos_ff + ADDR_W'(1);
               end
            end
         end
         ST_EMIT: begin
            if ((rd_ptr_ff == len_ff) && !pend_ff) begin
               state_in = ST_FILL;
            end
         end
         default: begin
            state_in = ST_FILL;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_FILL;
         fill_pos_ff <= '0;
         pend_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         fill_pos_ff <= fill_pos_in;
         pend_ff <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rd_ptr_ff <= rd_ptr_in;
      len_ff <= len_in;
      cut_ff <= cut_in;
      pend_last_ff <= pend_last_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
      rsp_len_ff <= rsp_len_in;
      rsp_cut_ff <= rsp_cut_in;
   end

   assign req_ready = (state_ff == ST_FILL);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;
   assign rsp_last_of_line = rsp_last_ff;
   assign rsp_line_length = rsp_len_ff;
   assign rsp_cut_by_full = rsp_cut_ff;

endmodule

>>> rtl/core/lf_checker.sv
module lf_checker (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_ready,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  logic [7:0]                rsp_out_byte,
   input  logic                      rsp_last_of_line,
   input  logic [lf_pkg::LEN_W-1:0]  rsp_line_length,
   input  logic                      rsp_cut_by_full
);
   import lf_pkg::*;

   // A stalled beat keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte)
         && $stable(rsp_last_of_line) && $stable(rsp_line_length)
         && $stable(rsp_cut_by_full))
      else $error("stalled output beat changed");

   // No byte is taken while a line is only partly delivered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_of_line |-> !req_ready)
      else $error("input taken during line readout");

   // A cut line always has the full store length.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_cut_by_full |-> rsp_line_length == LEN_W'(LINE_DEPTH))
      else $error("cut line with short length");

   // The length of a line stays the same from beat to beat.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_of_line |=>
         rsp_line_length == $past(rsp_line_length))
      else $error("line length changed within a line");

   // Every beat carries a nonzero length within the store size.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_line_length != '0 && rsp_line_length <= LEN_W'(LINE_DEPTH))
      else $error("line length out of range");

endmodule

bind line_framer_byte_to_line_core lf_checker u_lf_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_out_byte     (rsp_out_byte),
   .rsp_last_of_line (rsp_last_of_line),
   .rsp_line_length  (rsp_line_length),
   .rsp_cut_by_full  (rsp_cut_by_full)
);
